[hdl/mmscl_pkg.sv]
// Shared constants, codes and state type for the per-feature min-max scaler.
package mmscl_pkg;

  // Number of features and the index width that covers them
  localparam int FEATURES = 16;
  localparam int FIDX_W   = (FEATURES > 1) ? $clog2(FEATURES) : 1;

  // Datapath widths
  localparam int DVD_W = 48;             // |x - lo| * 65536
  localparam int DM_W  = 33;             // |dst_hi - dst_lo|
  localparam int ACC_W = DVD_W + DM_W;   // product width
  localparam int CNT_W = 6;

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DVD_W - 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(DM_W - 1);

  // Command codes
  localparam logic [2:0] CMD_CLEAR   = 3'd0;
  localparam logic [2:0] CMD_OBSERVE = 3'd1;
  localparam logic [2:0] CMD_FORWARD = 3'd2;
  localparam logic [2:0] CMD_INVERSE = 3'd3;
  localparam logic [2:0] CMD_TARGET  = 3'd4;

  // Status codes
  localparam logic [1:0] ST_NORMAL = 2'd0;
  localparam logic [1:0] ST_DEGEN  = 2'd1;
  localparam logic [1:0] ST_SAT    = 2'd2;

  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] TGT_HI_RST = 32'sd65536;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_MUL  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

endpackage

[hdl/per_feature_min_max_scaler.sv]
// Per-feature min-max scaler: statistics store, sequencer and shared add/sub unit.
//
// Each request carries one command for one feature and yields exactly one result.
// Clear, observe, set target and ignored commands finish in the accept cycle and
// present their result on the next cycle. Forward and inverse run 48 restoring-division
// steps, then 33 shift-add multiply steps, then a final state that clamps the product and
// saturates the sum, all on a single 81-bit add/subtract unit; a degenerate span skips
// the arithmetic and answers at once.
// The block takes no new request while a mapping is in progress or while a
// result waits that is not being taken in the same cycle.
module per_feature_min_max_scaler
  import mmscl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [30:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_command,
  input  logic [3:0]         in_feature,
  input  logic signed [31:0] in_value,
  input  logic signed [31:0] in_target_lo_in,
  input  logic signed [31:0] in_target_hi_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result,
  output logic [1:0]         out_status
);

  state_t state_r, state_nxt;

  logic [30:0] tol_r;

  logic signed [31:0] obs_min_r [FEATURES];
  logic signed [31:0] obs_max_r [FEATURES];
  logic signed [31:0] tgt_lo_r  [FEATURES];
  logic signed [31:0] tgt_hi_r  [FEATURES];

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [31:0]        rem_r, rem_nxt;
  logic [DVD_W-1:0]   dvd_r, dvd_nxt;
  logic [31:0]        span_r, span_nxt;
  logic [DM_W-1:0]    dm_r, dm_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic               negn_r, negn_nxt;
  logic               negd_r, negd_nxt;
  logic signed [31:0] dlo_r, dlo_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] out_result_r, out_result_nxt;
  logic [1:0]         out_status_r, out_status_nxt;

  // Feature index decode
  logic [FIDX_W+3:0] fext;
  logic [FIDX_W-1:0] fidx;
  logic              f_ok;
  assign fext = (FIDX_W + 4)'(in_feature);
  assign fidx = fext[FIDX_W-1:0];
  assign f_ok = (9'(in_feature) < 9'(FEATURES));

  logic accept;
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // Source and destination bounds of the selected mapping
  logic               is_inv;
  logic signed [31:0] slo, shi, dlo, dhi;
  assign is_inv = (in_command == CMD_INVERSE);
  assign slo = is_inv ? tgt_lo_r[fidx]  : obs_min_r[fidx];
  assign shi = is_inv ? tgt_hi_r[fidx]  : obs_max_r[fidx];
  assign dlo = is_inv ? obs_min_r[fidx] : tgt_lo_r[fidx];
  assign dhi = is_inv ? obs_max_r[fidx] : tgt_hi_r[fidx];

  // Setup arithmetic at accept: spans, numerator magnitude, degenerate test
  logic signed [32:0] span33, diff33, dsp33;
  logic [32:0]        diff_mag, dsp_mag;
  logic               degen;
  assign span33   = 33'(shi) - 33'(slo);
  assign diff33   = 33'(in_value) - 33'(slo);
  assign dsp33    = 33'(dhi) - 33'(dlo);
  assign diff_mag = diff33[32] ? 33'(-diff33) : 33'(diff33);
  assign dsp_mag  = dsp33[32] ? 33'(-dsp33) : 33'(dsp33);
  assign degen    = (span33 <= $signed({2'b00, tol_r}));

  // Shared add/subtract unit
  logic [ACC_W-1:0] alu_a, alu_b, alu_y;
  logic             alu_sub;
  logic [32:0]      rem_sh;
  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    if (state_r == S_DIV) begin
      alu_a   = ACC_W'(rem_sh);
      alu_b   = ACC_W'(span_r);
      alu_sub = 1'b1;
    end else begin
      alu_a   = {acc_r[ACC_W-2:0], 1'b0};
      alu_b   = dm_r[DM_W-1] ? ACC_W'(dvd_r) : '0;
    end
  end
  assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + ACC_W'(alu_sub);

  // Final scaling: clamp the shifted product, add to the low bound, saturate
  logic               q_ovf, negr;
  logic [40:0]        q41;
  logic signed [41:0] sum42;
  assign q_ovf = (|acc_r[ACC_W-1:57]) || (acc_r[56] && (|acc_r[55:16]));
  assign q41   = q_ovf ? (41'd1 << 40) : acc_r[56:16];
  assign negr  = (negn_r && (|dvd_r)) != negd_r;
  assign sum42 = 42'(dlo_r) + (negr ? -$signed(42'(q41)) : $signed(42'(q41)));

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    rem_nxt        = rem_r;
    dvd_nxt        = dvd_r;
    span_nxt       = span_r;
    dm_nxt         = dm_r;
    acc_nxt        = acc_r;
    negn_nxt       = negn_r;
    negd_nxt       = negd_r;
    dlo_nxt        = dlo_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_result_nxt = out_result_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_result_nxt = '0;
          out_status_nxt = ST_NORMAL;
          out_valid_nxt  = 1'b1;
          if (f_ok && (in_command == CMD_FORWARD || in_command == CMD_INVERSE)) begin
            if (degen) begin
              out_result_nxt = dlo;
              out_status_nxt = ST_DEGEN;
            end else begin
              out_valid_nxt = 1'b0;
              rem_nxt   = '0;
              dvd_nxt   = {diff_mag[31:0], 16'h0000};
              span_nxt  = span33[31:0];
              dm_nxt    = dsp_mag;
              negn_nxt  = diff33[32];
              negd_nxt  = dsp33[32];
              dlo_nxt   = dlo;
              acc_nxt   = '0;
              cnt_nxt   = DIV_LAST;
              state_nxt = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        // one restoring step: quotient bit enters the dividend register
        if (alu_y[ACC_W-1]) begin
          rem_nxt = rem_sh[31:0];
          dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
        end else begin
          rem_nxt = alu_y[31:0];
          dvd_nxt = {dvd_r[DVD_W-2:0], 1'b1};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          cnt_nxt   = MUL_LAST;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // MSB-first shift-add over the destination span
        acc_nxt = alu_y;
        dm_nxt  = {dm_r[DM_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        out_valid_nxt = 1'b1;
        if (sum42 > 42'(VAL_MAX)) begin
          out_result_nxt = VAL_MAX;
          out_status_nxt = ST_SAT;
        end else if (sum42 < 42'(VAL_MIN)) begin
          out_result_nxt = VAL_MIN;
          out_status_nxt = ST_SAT;
        end else begin
          out_result_nxt = sum42[31:0];
          out_status_nxt = ST_NORMAL;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      tol_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tol_r <= cfg_wdata;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    rem_r        <= rem_nxt;
    dvd_r        <= dvd_nxt;
    span_r       <= span_nxt;
    dm_r         <= dm_nxt;
    acc_r        <= acc_nxt;
    negn_r       <= negn_nxt;
    negd_r       <= negd_nxt;
    dlo_r        <= dlo_nxt;
    out_result_r <= out_result_nxt;
    out_status_r <= out_status_nxt;
  end

  // Per-feature statistics and targets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FEATURES; i++) begin
        obs_min_r[i] <= VAL_MAX;
        obs_max_r[i] <= VAL_MIN;
        tgt_lo_r[i]  <= '0;
        tgt_hi_r[i]  <= TGT_HI_RST;
      end
    end else if (accept) begin
      if (in_command == CMD_CLEAR) begin
        for (int i = 0; i < FEATURES; i++) begin
          obs_min_r[i] <= VAL_MAX;
          obs_max_r[i] <= VAL_MIN;
        end
      end else if (f_ok && in_command == CMD_OBSERVE) begin
        if (in_value < obs_min_r[fidx]) obs_min_r[fidx] <= in_value;
        if (in_value > obs_max_r[fidx]) obs_max_r[fidx] <= in_value;
      end else if (f_ok && in_command == CMD_TARGET) begin
        tgt_lo_r[fidx] <= in_target_lo_in;
        tgt_hi_r[fidx] <= in_target_hi_in;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;
  assign out_status = out_status_r;

  // Output register stays empty while a mapping is in progress
  a_busy_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV || state_r == S_MUL || state_r == S_FIN) |-> !out_valid_r)
    else $error("result pending during mapping");

  // A non-degenerate mapping request starts the divider
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && f_ok && !degen &&
     (in_command == CMD_FORWARD || in_command == CMD_INVERSE)) |=> state_r == S_DIV)
    else $error("mapping did not start division");

  // Division hands over to the multiplier on its last step
  a_div_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == '0) |=> (state_r == S_MUL && cnt_r == MUL_LAST))
    else $error("divider handover");

  // Saturated status carries a clamp limit
  a_sat_val: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_SAT) |->
      (out_result_r == VAL_MAX || out_result_r == VAL_MIN))
    else $error("saturated result not at a limit");

endmodule

[tb/mmscl_checker.sv]
// Checker for the min-max scaler: predicts each result from accepted requests and compares.
module mmscl_checker
  import mmscl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [30:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         in_command,
  input  logic [3:0]         in_feature,
  input  logic signed [31:0] in_value,
  input  logic signed [31:0] in_target_lo_in,
  input  logic signed [31:0] in_target_hi_in,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_result,
  input  logic [1:0]         out_status,
  output int                 fail_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] result;
    logic [1:0]         status;
  } scaled_t;

  scaled_t scaled_q[$];

  logic [30:0]        tol;
  logic signed [31:0] obs_min [FEATURES];
  logic signed [31:0] obs_max [FEATURES];
  logic signed [31:0] tgt_lo  [FEATURES];
  logic signed [31:0] tgt_hi  [FEATURES];

  assign pending_count = scaled_q.size();

  // Two-step truncating map with saturation
  function automatic scaled_t map_span(input logic signed [31:0] x,
                                       input logic signed [31:0] slo,
                                       input logic signed [31:0] shi,
                                       input logic signed [31:0] dlo,
                                       input logic signed [31:0] dhi);
    scaled_t r;
    longint span, frac, dspan, sum;
    logic [127:0] prod;
    logic [63:0] mag;
    logic neg;
    span = longint'(shi) - longint'(slo);
    r.status = ST_NORMAL;
    if (span <= longint'({33'd0, tol})) begin
      r.result = dlo;
      r.status = ST_DEGEN;
      return r;
    end
    frac = ((longint'(x) - longint'(slo)) * 64'sd65536) / span;
    dspan = longint'(dhi) - longint'(dlo);
    neg = (frac < 0) != (dspan < 0);
    prod = 128'(frac < 0 ? -frac : frac) * 128'(dspan < 0 ? -dspan : dspan);
    prod = prod >> 16;
    mag = (prod > (128'd1 << 40)) ? (64'd1 << 40) : prod[63:0];
    sum = longint'(dlo) + (neg ? -longint'(mag) : longint'(mag));
    if (sum > 64'sh7fff_ffff) begin
      r.result = VAL_MAX;
      r.status = ST_SAT;
    end else if (sum < -64'sh8000_0000) begin
      r.result = VAL_MIN;
      r.status = ST_SAT;
    end else begin
      r.result = sum[31:0];
    end
    return r;
  endfunction

  // Apply one request to the shadow state, return its result
  function automatic scaled_t apply_request(input logic [2:0] c, input logic [3:0] f,
                                            input logic signed [31:0] v,
                                            input logic signed [31:0] lo,
                                            input logic signed [31:0] hi);
    scaled_t r;
    r = '0;
    case (c)
      CMD_CLEAR: begin
        for (int i = 0; i < FEATURES; i++) begin
          obs_min[i] = VAL_MAX;
          obs_max[i] = VAL_MIN;
        end
      end
      CMD_OBSERVE: begin
        if (v < obs_min[f]) obs_min[f] = v;
        if (v > obs_max[f]) obs_max[f] = v;
      end
      CMD_FORWARD: r = map_span(v, obs_min[f], obs_max[f], tgt_lo[f], tgt_hi[f]);
      CMD_INVERSE: r = map_span(v, tgt_lo[f], tgt_hi[f], obs_min[f], obs_max[f]);
      CMD_TARGET: begin
        tgt_lo[f] = lo;
        tgt_hi[f] = hi;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    scaled_t e;
    int errs;
    errs = 0;
    if (!rst_n) begin
      tol = '0;
      for (int i = 0; i < FEATURES; i++) begin
        obs_min[i] = VAL_MAX;
        obs_max[i] = VAL_MIN;
        tgt_lo[i]  = '0;
        tgt_hi[i]  = TGT_HI_RST;
      end
      scaled_q.delete();
      fail_count <= 0;
    end else begin
      // Result side first: it belongs to an earlier request
      if (out_valid && out_ready) begin
        if (scaled_q.size() == 0) begin
          $error("result with no request pending: result=%0d status=%0d",
                 out_result, out_status);
          errs++;
        end else begin
          e = scaled_q.pop_front();
          if (out_result !== e.result) begin
            $error("result: expected %0d, got %0d", e.result, out_result);
            errs++;
          end
          if (out_status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_status);
            errs++;
          end
        end
      end
      if (in_valid && in_ready)
        scaled_q.push_back(apply_request(in_command, in_feature, in_value,
                                         in_target_lo_in, in_target_hi_in));
      if (cfg_we) tol = cfg_wdata;
      fail_count <= fail_count + errs;
    end
  end
endmodule

[tb/tb.sv]
// Testbench top for the min-max scaler: stimulus, configuration phases and verdict.
module tb;
  import mmscl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [30:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_command = '0;
  logic [3:0] in_feature = '0;
  logic signed [31:0] in_value = '0, in_target_lo_in = '0, in_target_hi_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_result;
  logic [1:0] out_status;
  int fail_count, pending_count;
  int idle_cycles = 0;
  bit quiet_tail = 1'b0;

  always #10 clk = ~clk;

  per_feature_min_max_scaler dut (.*);
  mmscl_checker u_chk (.*);

  // Receiver stalls in bursts, none in the tail
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        n = $urandom_range(1, 6);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without a handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(0, 5))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      3: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      default: return $urandom;
    endcase
  endfunction

  // Send one request, sometimes with a random idle burst beforehand
  task automatic send_request(input logic [2:0] c, input logic [3:0] f,
                              input logic signed [31:0] v,
                              input logic signed [31:0] lo,
                              input logic signed [31:0] hi);
    int n;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 6);
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= c;
    in_feature <= f;
    in_value <= v;
    in_target_lo_in <= lo;
    in_target_hi_in <= hi;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Wait until every result has come, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_tolerance(input logic [30:0] t);
    cfg_we <= 1'b1;
    cfg_wdata <= t;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_request();
    logic [2:0] c;
    int p;
    p = $urandom_range(0, 99);
    if (p < 2) c = CMD_CLEAR;
    else if (p < 35) c = CMD_OBSERVE;
    else if (p < 60) c = CMD_FORWARD;
    else if (p < 82) c = CMD_INVERSE;
    else if (p < 96) c = CMD_TARGET;
    else c = 3'($urandom_range(5, 7));
    send_request(c, 4'($urandom), rand_q16(), rand_q16(), rand_q16());
  endtask

  initial begin
    logic [30:0] tols [4];
    tols = '{31'd0, 31'h7fff_ffff, 31'd65536, 31'd3};
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: degenerate spans on empty stats, then extremes
    send_request(CMD_FORWARD, 4'd0, 32'sd100, '0, '0);
    send_request(CMD_INVERSE, 4'd15, VAL_MAX, '0, '0);
    send_request(CMD_OBSERVE, 4'd0, VAL_MIN, '0, '0);
    send_request(CMD_OBSERVE, 4'd0, VAL_MAX, '0, '0);
    send_request(CMD_FORWARD, 4'd0, 32'sd0, '0, '0);
    send_request(CMD_FORWARD, 4'd0, VAL_MAX, '0, '0);
    send_request(CMD_INVERSE, 4'd0, VAL_MAX, '0, '0);
    send_request(CMD_INVERSE, 4'd0, VAL_MIN, '0, '0);
    send_request(CMD_TARGET, 4'd1, '0, VAL_MAX, VAL_MIN);
    send_request(CMD_OBSERVE, 4'd1, 32'sd0, '0, '0);
    send_request(CMD_OBSERVE, 4'd1, 32'sd65536, '0, '0);
    send_request(CMD_FORWARD, 4'd1, 32'sd32768, '0, '0);
    send_request(CMD_FORWARD, 4'd1, VAL_MIN, '0, '0);
    send_request(CMD_TARGET, 4'd2, '0, VAL_MIN, VAL_MAX);
    send_request(CMD_OBSERVE, 4'd2, -32'sd65536, '0, '0);
    send_request(CMD_OBSERVE, 4'd2, 32'sd65536, '0, '0);
    send_request(CMD_FORWARD, 4'd2, VAL_MAX, '0, '0);
    send_request(CMD_FORWARD, 4'd2, VAL_MIN, '0, '0);
    send_request(CMD_INVERSE, 4'd2, 32'sd12345, '0, '0);
    send_request(3'd5, 4'd3, VAL_MIN, '0, '0);
    send_request(3'd7, 4'd3, 32'sd1, '0, '0);
    send_request(CMD_CLEAR, 4'd9, '0, '0, '0);
    send_request(CMD_FORWARD, 4'd2, 32'sd1, '0, '0);

    // Random phases, one tolerance each; sender waits for all results between
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_tolerance(tols[ph]);
      if (ph == 3) quiet_tail = 1'b1;
      for (int i = 0; i < 270; i++) random_request();
    end

    drain();
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
